// ===== hdl/tarpd_pkg.sv =====
// ---------------------------------------------------------------------------
// tarpd_pkg: shared types and constants of the two-axis reference controller
// Register indexes, the sequencer state type and the datapath command struct.
// ---------------------------------------------------------------------------
`default_nettype none

package tarpd_pkg;

    localparam int unsigned NumRegs = 7;
    localparam int unsigned RegWidth = 24;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [CfgIdxWidth-1:0] RegTiltW = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegElevW = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegRefXi = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegInvJ = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegMass = 3'd4;
    localparam logic [CfgIdxWidth-1:0] RegLoopW = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegLoopXi = 3'd6;

    localparam logic [RegWidth-1:0] RegReset [NumRegs] = '{
        24'd228764, 24'd137258, 24'd65536, 24'd131072,
        24'd327680, 24'd686291, 24'd65536
    };

    localparam int unsigned DtShift = 9;
    localparam logic signed [33:0] ThrustOffset = 34'sd2621440;

    // One step of the sequencer. Apart from idle, load and done, each names one
    // multiplication performed by the shared multiplier in the datapath.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,     // restart load and dt integration of both axes
        ST_T_DAMP,   // tw*xi
        ST_T_STIFF,  // tw*tw
        ST_T_A1,     // tdamp*rate
        ST_T_A2,     // tstiff*err
        ST_E_DAMP,
        ST_E_STIFF,
        ST_E_A1,
        ST_E_A2,
        ST_KD,       // lxi*lw
        ST_KP,       // lw*lw
        ST_P_FF,     // invj*tacc
        ST_P_D1,     // kd*e_td
        ST_P_D2,     // invj*that
        ST_P_P1,     // kp*e_t
        ST_P_P2,
        ST_H_FF,     // mass*eacc
        ST_H_D1,
        ST_H_D2,
        ST_H_P1,
        ST_H_P2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic   capture;
        state_t op;
    } cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tarpd_ctrl.sv =====
// ---------------------------------------------------------------------------
// tarpd_ctrl: sequencer of the two-axis reference controller
// Steps the datapath through its multiplications one per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tarpd_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_fire,
    input  wire logic            out_free,
    output tarpd_pkg::cmd_t      cmd,
    output logic                 busy,
    output logic                 result_done
);

    tarpd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tarpd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.capture = 1'b0;
        cmd.op = state_reg;
        result_done = 1'b0;
        busy = (state_reg != tarpd_pkg::ST_IDLE);
        case (state_reg)
            tarpd_pkg::ST_IDLE: begin
                if (in_fire) begin
                    cmd.capture = 1'b1;
                    state_next = tarpd_pkg::ST_LOAD;
                end
            end
            tarpd_pkg::ST_DONE: begin
                // The sum is written into the output register when it is free.
                if (out_free) begin
                    result_done = 1'b1;
                    state_next = tarpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tarpd_pkg::state_t'(state_reg + 5'd1);
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tarpd_dp.sv =====
// ---------------------------------------------------------------------------
// tarpd_dp: datapath of the two-axis reference controller
// Holds registers, axis state and operands around one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module tarpd_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_idx,
    input  wire logic [23:0]         cfg_data,
    input  wire logic [31:0]         in_tilt,
    input  wire logic [31:0]         in_tilt_rate,
    input  wire logic [31:0]         in_elev,
    input  wire logic [31:0]         in_elev_rate,
    input  wire logic [31:0]         in_tsp,
    input  wire logic [31:0]         in_esp,
    input  wire logic                in_restart,
    input  tarpd_pkg::cmd_t          cmd,
    output logic signed [31:0]       pitch,
    output logic [30:0]              thrust
);

    logic [23:0] regs_reg [tarpd_pkg::NumRegs];

    logic signed [31:0] mt_reg, mtr_reg, me_reg, mer_reg, tsp_reg, esp_reg;
    logic               rs_reg;

    logic signed [31:0] tpos_reg, trate_reg, tacc_reg;
    logic signed [31:0] epos_reg, erate_reg, eacc_reg;

    // Scratch: damping/kd, stiffness/kp, first product, running sum.
    logic signed [31:0] damp_reg, stiff_reg, t1_reg;
    logic signed [33:0] sum_reg;
    // The pitch sum is kept here while the thrust sum reuses sum_reg.
    logic signed [31:0] pitch_reg;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [31:0] err_t, err_e, e_t, e_td, e_e, e_ed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tarpd_pkg::NumRegs; i++) begin
                regs_reg[i] <= tarpd_pkg::RegReset[i];
            end
        end else if (cfg_we && (cfg_idx < 3'(tarpd_pkg::NumRegs))) begin
            regs_reg[cfg_idx] <= cfg_data;
        end
    end

    function automatic logic signed [31:0] sx(input logic [31:0] a, input logic [31:0] b);
        return tarpd_pkg::sat32(36'(signed'(a)) - 36'(signed'(b)));
    endfunction

    assign err_t = sx(tpos_reg, tsp_reg);
    assign err_e = sx(epos_reg, esp_reg);
    assign e_t = sx(mt_reg, tpos_reg);
    assign e_td = sx(mtr_reg, trate_reg);
    assign e_e = sx(me_reg, epos_reg);
    assign e_ed = sx(mer_reg, erate_reg);

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            tarpd_pkg::ST_T_DAMP: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegTiltW]};
                mb = {8'd0, regs_reg[tarpd_pkg::RegRefXi]};
            end
            tarpd_pkg::ST_T_STIFF: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegTiltW]};
                mb = {8'd0, regs_reg[tarpd_pkg::RegTiltW]};
            end
            tarpd_pkg::ST_T_A1, tarpd_pkg::ST_E_A1: begin
                ma = damp_reg;
                mb = (cmd.op == tarpd_pkg::ST_T_A1) ? trate_reg : erate_reg;
            end
            tarpd_pkg::ST_T_A2: begin
                ma = stiff_reg;
                mb = err_t;
            end
            tarpd_pkg::ST_E_DAMP: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegElevW]};
                mb = {8'd0, regs_reg[tarpd_pkg::RegRefXi]};
            end
            tarpd_pkg::ST_E_STIFF: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegElevW]};
                mb = {8'd0, regs_reg[tarpd_pkg::RegElevW]};
            end
            tarpd_pkg::ST_E_A2: begin
                ma = stiff_reg;
                mb = err_e;
            end
            tarpd_pkg::ST_KD: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegLoopXi]};
                mb = {8'd0, regs_reg[tarpd_pkg::RegLoopW]};
            end
            tarpd_pkg::ST_KP: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegLoopW]};
                mb = {8'd0, regs_reg[tarpd_pkg::RegLoopW]};
            end
            tarpd_pkg::ST_P_FF: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegInvJ]};
                mb = tacc_reg;
            end
            tarpd_pkg::ST_P_D1: begin
                ma = damp_reg;
                mb = e_td;
            end
            tarpd_pkg::ST_P_P1: begin
                ma = stiff_reg;
                mb = e_t;
            end
            tarpd_pkg::ST_P_D2, tarpd_pkg::ST_P_P2: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegInvJ]};
                mb = t1_reg;
            end
            tarpd_pkg::ST_H_FF: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegMass]};
                mb = eacc_reg;
            end
            tarpd_pkg::ST_H_D1: begin
                ma = damp_reg;
                mb = e_ed;
            end
            tarpd_pkg::ST_H_P1: begin
                ma = stiff_reg;
                mb = e_e;
            end
            tarpd_pkg::ST_H_D2, tarpd_pkg::ST_H_P2: begin
                ma = {8'd0, regs_reg[tarpd_pkg::RegMass]};
                mb = t1_reg;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // Arithmetic shift is floor; saturate the Q16.16 result.
    assign prod = ma * mb;

    logic signed [47:0] shq;
    logic signed [31:0] qs;
    assign shq = prod[63:16];
    always_comb begin
        if (shq > 48'sd2147483647) begin
            qs = 32'sh7fffffff;
        end else if (shq < -48'sd2147483648) begin
            qs = 32'sh80000000;
        end else begin
            qs = shq[31:0];
        end
    end

    logic signed [31:0] q2;
    assign q2 = tarpd_pkg::sat32({{3{qs[31]}}, qs, 1'b0});

    logic signed [31:0] tpos_i, trate_i, tacc_i, epos_i, erate_i, eacc_i;
    assign tpos_i = rs_reg ? mt_reg : tpos_reg;
    assign trate_i = rs_reg ? mtr_reg : trate_reg;
    assign tacc_i = rs_reg ? 32'sd0 : tacc_reg;
    assign epos_i = rs_reg ? me_reg : epos_reg;
    assign erate_i = rs_reg ? mer_reg : erate_reg;
    assign eacc_i = rs_reg ? 32'sd0 : eacc_reg;

    logic signed [35:0] acc_sum;
    assign acc_sum = -36'(t1_reg) - 36'(qs);

    logic signed [35:0] thr_full;
    assign thr_full = 36'(sum_reg) + 36'(tarpd_pkg::ThrustOffset);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpos_reg <= '0;
            trate_reg <= '0;
            tacc_reg <= '0;
            epos_reg <= '0;
            erate_reg <= '0;
            eacc_reg <= '0;
        end else begin
            case (cmd.op)
                tarpd_pkg::ST_LOAD: begin
                    tpos_reg <= tarpd_pkg::sat32(36'(tpos_i) + 36'(trate_i >>> tarpd_pkg::DtShift));
                    trate_reg <= tarpd_pkg::sat32(36'(trate_i) + 36'(tacc_i >>> tarpd_pkg::DtShift));
                    epos_reg <= tarpd_pkg::sat32(36'(epos_i) + 36'(erate_i >>> tarpd_pkg::DtShift));
                    erate_reg <= tarpd_pkg::sat32(36'(erate_i) + 36'(eacc_i >>> tarpd_pkg::DtShift));
                end
                tarpd_pkg::ST_T_A2: tacc_reg <= tarpd_pkg::sat32(acc_sum);
                tarpd_pkg::ST_E_A2: eacc_reg <= tarpd_pkg::sat32(acc_sum);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mt_reg <= in_tilt;
            mtr_reg <= in_tilt_rate;
            me_reg <= in_elev;
            mer_reg <= in_elev_rate;
            tsp_reg <= in_tsp;
            esp_reg <= in_esp;
            rs_reg <= in_restart;
        end
        case (cmd.op)
            tarpd_pkg::ST_T_DAMP, tarpd_pkg::ST_E_DAMP, tarpd_pkg::ST_KD: damp_reg <= q2;
            tarpd_pkg::ST_T_STIFF, tarpd_pkg::ST_E_STIFF, tarpd_pkg::ST_KP: stiff_reg <= qs;
            tarpd_pkg::ST_T_A1, tarpd_pkg::ST_E_A1, tarpd_pkg::ST_P_D1, tarpd_pkg::ST_P_P1,
            tarpd_pkg::ST_H_D1, tarpd_pkg::ST_H_P1: t1_reg <= qs;
            tarpd_pkg::ST_P_FF: sum_reg <= 34'(qs);
            tarpd_pkg::ST_H_FF: begin
                pitch_reg <= tarpd_pkg::sat32(36'(sum_reg));
                sum_reg <= 34'(qs);
            end
            tarpd_pkg::ST_P_D2, tarpd_pkg::ST_P_P2: sum_reg <= sum_reg + 34'(qs);
            tarpd_pkg::ST_H_D2, tarpd_pkg::ST_H_P2: sum_reg <= sum_reg - 34'(qs);
            default: begin
            end
        endcase
    end

    logic signed [31:0] thr_sat;
    assign pitch = pitch_reg;
    assign thr_sat = tarpd_pkg::sat32(thr_full);
    assign thrust = thr_sat[31] ? 31'd0 : thr_sat[30:0];

endmodule

`default_nettype wire

// ===== hdl/two_axis_reference_model_pd_controller.sv =====
// ---------------------------------------------------------------------------
// two_axis_reference_model_pd_controller: reference trajectories with PD control
// Steps two second-order reference trajectories and forms pitch and thrust.
// ---------------------------------------------------------------------------
// Usage. One input item per control tick arrives on s_axis_*: tdata carries
// the four measurements and two setpoints, tuser the restart flag. The block
// steps the tilt and elevation reference trajectories and returns one result
// item on m_axis_* with the pitch and thrust commands.
// Throughput: the single shared 32x32 multiplier performs the twenty
// multiplications one per cycle, and one item is worked at a time, so a
// new item is accepted only after the previous one has left the sequencer.
// The next item is accepted once the result has moved to the output
// register, so a waiting result does not hold up the following item's work
// until that item's own result is ready.
// Reset (aresetn low, synchronous) clears the reference states to zero,
// restores the register defaults and empties the output register.
// If the receiver stalls, the result stays in the output register unchanged.
// Registers on cfg_* must be written only while the block is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module two_axis_reference_model_pd_controller (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // measured_tilt, measured_tilt_rate, measured_elevation,
    // measured_elevation_rate, tilt_setpoint, elevation_setpoint
    input  wire logic [191:0] s_axis_tdata,
    // restart
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pitch_command, thrust_command, one zero pad bit
    output logic [63:0]       m_axis_tdata
);

    tarpd_pkg::cmd_t cmd;
    logic busy, result_done, in_fire, out_free;
    logic signed [31:0] pitch;
    logic [30:0] thrust;
    logic valid_reg;
    logic [62:0] data_reg;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !valid_reg || m_axis_tready;

    tarpd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .cmd(cmd), .busy(busy), .result_done(result_done)
    );

    tarpd_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_tilt(s_axis_tdata[31:0]), .in_tilt_rate(s_axis_tdata[63:32]),
        .in_elev(s_axis_tdata[95:64]), .in_elev_rate(s_axis_tdata[127:96]),
        .in_tsp(s_axis_tdata[159:128]), .in_esp(s_axis_tdata[191:160]),
        .in_restart(s_axis_tuser), .cmd(cmd), .pitch(pitch), .thrust(thrust)
    );

    // Output register: filled when the sequencer finishes, emptied on handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (result_done) begin
            valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_done) begin
            data_reg <= {thrust, pitch};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = {1'b0, data_reg};

endmodule

`default_nettype wire

// ===== dv/two_axis_reference_model_pd_controller_test.sv =====
// ---------------------------------------------------------------------------
// two_axis_reference_model_pd_controller_test: self-checking testbench
// Drives measurement items with random gaps and stalls, predicts the pitch and
// thrust commands with a fixed-point model of both axes and checks each item.
// ---------------------------------------------------------------------------
`default_nettype none

module two_axis_reference_model_pd_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] pitch;
        logic [30:0]        thrust;
    } command_t;

    // Scoreboard: a fixed-point copy of the controller and a queue of the
    // commands it predicts.
    class command_scoreboard;
        logic [23:0]        regs [tarpd_pkg::NumRegs];
        logic signed [31:0] pos [2];
        logic signed [31:0] rate [2];
        logic signed [31:0] acc [2];
        command_t           pending [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < tarpd_pkg::NumRegs; i++) regs[i] = tarpd_pkg::RegReset[i];
            for (int a = 0; a < 2; a++) begin
                pos[a] = 0;
                rate[a] = 0;
                acc[a] = 0;
            end
            mismatches = 0;
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Floor of the product over 2^16, then saturated.
        function longint fmul(longint a, longint b);
            longint p;
            p = a * b;
            return clip(p >>> 16);
        endfunction

        function void advance_axis(int a, longint w, longint xi, longint sp);
            longint np, nr, damp, stiff, err, na;
            np = clip(longint'(pos[a]) + (longint'(rate[a]) >>> tarpd_pkg::DtShift));
            nr = clip(longint'(rate[a]) + (longint'(acc[a]) >>> tarpd_pkg::DtShift));
            damp = clip(2 * fmul(w, xi));
            stiff = fmul(w, w);
            err = clip(np - sp);
            na = clip(-fmul(damp, nr) - fmul(stiff, err));
            pos[a] = np;
            rate[a] = nr;
            acc[a] = na;
        endfunction

        function void note_item(logic [191:0] d, logic restart);
            longint m [6];
            longint kd, kp, ij, ms, pitch, thrust;
            command_t c;
            for (int i = 0; i < 6; i++) m[i] = longint'($signed(d[32*i +: 32]));
            if (restart) begin
                pos[0] = m[0]; rate[0] = m[1]; acc[0] = 0;
                pos[1] = m[2]; rate[1] = m[3]; acc[1] = 0;
            end
            advance_axis(0, regs[tarpd_pkg::RegTiltW], regs[tarpd_pkg::RegRefXi], m[4]);
            advance_axis(1, regs[tarpd_pkg::RegElevW], regs[tarpd_pkg::RegRefXi], m[5]);
            kd = clip(2 * fmul(regs[tarpd_pkg::RegLoopXi], regs[tarpd_pkg::RegLoopW]));
            kp = fmul(regs[tarpd_pkg::RegLoopW], regs[tarpd_pkg::RegLoopW]);
            ij = regs[tarpd_pkg::RegInvJ];
            ms = regs[tarpd_pkg::RegMass];
            pitch = clip(fmul(ij, acc[0])
                         + fmul(ij, fmul(kd, clip(m[1] - rate[0])))
                         + fmul(ij, fmul(kp, clip(m[0] - pos[0]))));
            thrust = clip(fmul(ms, acc[1])
                          - fmul(ms, fmul(kd, clip(m[3] - rate[1])))
                          - fmul(ms, fmul(kp, clip(m[2] - pos[1])))
                          + 64'sd2621440);
            if (thrust < 0) thrust = 0;
            c.pitch = pitch[31:0];
            c.thrust = thrust[30:0];
            pending.push_back(c);
        endfunction

        function void check_result(logic [63:0] d);
            command_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing pending: %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.pitch || d[62:32] !== e.thrust || d[63] !== 1'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("command mismatch: expected pitch %h thrust %h, got %h",
                             e.pitch, e.thrust, d);
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [23:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;   // tilt, tilt rate, elevation, elevation rate, setpoints
    logic         s_axis_tuser;   // restart
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // pitch, thrust, zero pad bit

    command_scoreboard board;
    int  cycles;
    bit  hold_sink;   // set while the receiver is held off for a long stretch

    two_axis_reference_model_pd_controller dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Often no gap, otherwise mostly a short one and now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // A field value that leans towards the extremes and small magnitudes, so
    // that saturation and the ordinary operating range are both covered.
    function automatic logic [31:0] field_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    // The write strobe drops for a cycle after each write, so the next write
    // starts at a later edge.
    task automatic write_register(logic [2:0] idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.regs[idx] = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // tvalid stays high across back-to-back items and drops only for a gap.
    task automatic send_item(logic [191:0] d, logic restart);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= restart;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_item(d, restart);
    endtask

    // Waits until every predicted command has arrived, then lets the block's
    // latency pass so that it is idle before any register write.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic random_items(int count);
        logic [191:0] d;
        for (int n = 0; n < count; n++) begin
            for (int f = 0; f < 6; f++) d[32*f +: 32] = field_value();
            send_item(d, $urandom_range(0, 15) == 0);
        end
    endtask

    // The receiver stalls at random, and holds off for a long stretch
    // whenever hold_sink is set.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                @(posedge aclk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
                repeat ($urandom_range(0, 9) == 0 ? gap_length() + 1 : 1) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    // Generous limit on the run as a whole.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("two_axis_reference_model_pd_controller_test: errors");
            $finish;
        end
    end

    initial begin
        logic [191:0] d;
        board = new();
        cycles = 0;
        hold_sink = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings: zeros, the field extremes on
        // every input, a restart with extremes, and a restart flag on its own.
        send_item('0, 1'b0);
        send_item('0, 1'b1);
        for (int f = 0; f < 6; f++) begin
            d = '0;
            d[32*f +: 32] = 32'h7fffffff;
            send_item(d, 1'b0);
            d[32*f +: 32] = 32'h80000000;
            send_item(d, 1'b1);
        end
        send_item({6{32'h7fffffff}}, 1'b1);
        send_item({6{32'h80000000}}, 1'b1);
        send_item({6{32'h80000000}}, 1'b0);
        send_item({6{32'hffffffff}}, 1'b0);
        send_item({32'h00010000, 32'hfffe0000, 96'h0, 32'h00008000}, 1'b1);
        send_item({32'h00010000, 32'hfffe0000, 128'h0}, 1'b0);
        drain();

        // Largest gains: saturation right through the datapath.
        for (int i = 0; i < tarpd_pkg::NumRegs; i++) write_register(i[2:0], 24'hffffff);
        random_items(20);
        drain();

        // All registers zero: thrust comes from the offset alone.
        for (int i = 0; i < tarpd_pkg::NumRegs; i++) write_register(i[2:0], 24'h000000);
        random_items(20);
        drain();

        // Several random settings, each followed by a run of random items.
        for (int phase = 0; phase < 6; phase++) begin
            for (int i = 0; i < tarpd_pkg::NumRegs; i++)
                write_register(i[2:0],
                               24'(phase[0] ? $urandom() : $urandom_range(0, 1048575)));
            if (phase == 2) begin
                // The receiver holds off while items keep coming, so that the
                // block fills up and stalls its input.
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (400) @(posedge aclk);
                        hold_sink = 1'b0;
                    end
                    random_items(300);
                join
            end else begin
                random_items(300);
            end
            // The sender pauses until every predicted command has come back.
            drain();
        end

        // Back to the reset settings for a final stretch.
        for (int i = 0; i < tarpd_pkg::NumRegs; i++)
            write_register(i[2:0], tarpd_pkg::RegReset[i]);
        random_items(100);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("two_axis_reference_model_pd_controller_test: clean");
        end else begin
            $display("two_axis_reference_model_pd_controller_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/tarpd_pkg.sv
hdl/tarpd_ctrl.sv
hdl/tarpd_dp.sv
hdl/two_axis_reference_model_pd_controller.sv
dv/two_axis_reference_model_pd_controller_test.sv
